/* hw/rtl/qtsplit_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the quadtree splitter.
package qtsplit_pkg;

    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int STACK_DEPTH_DEF = 32;

    localparam int PADDR_W = 5;

    localparam logic [8:0]  WIDTH_RST  = 9'd256;
    localparam logic [8:0]  HEIGHT_RST = 9'd256;
    localparam logic [8:0]  MEAN_RST   = 9'd95;
    localparam logic [7:0]  STD_RST    = 8'd10;
    localparam logic [8:0]  CELL_RST   = 9'd32;

    localparam logic [7:0]  MASK_ON   = 8'd255;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_RUN   = 2'd1,
        FN_READ  = 2'd2,
        FN_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_MEAN   = 3'd2,
        REG_STD    = 3'd3,
        REG_CELL   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        OUT_ZERO  = 2'd0,
        OUT_MASK  = 2'd1,
        OUT_COUNT = 2'd2
    } out_sel_t;

    // products formed by the serial multiplier, in the order they are taken
    typedef enum logic [2:0] {
        MS_NQ  = 3'd0,
        MS_SS  = 3'd1,
        MS_DN  = 3'd2,
        MS_DNN = 3'd3,
        MS_MN  = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     img_we;
        logic     out_load;
        out_sel_t out_sel;
        logic     rd_latch;
        logic     clr_init;
        logic     clr_step;
        logic     stk_init;
        logic     pop;
        logic     region_load;
        logic     clip_load;
        logic     setup;
        logic     walk_init;
        logic     walk_step;
        logic     scan_rd;
        logic     mask_mark;
        logic     mul_load;
        logic     mul_store;
        mul_sel_t mul_sel;
        logic     count_inc;
        logic     push_init;
        logic     push;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sp_zero;
        logic empty;
        logic walk_last;
        logic mul_done;
        logic mark_ok;
        logic split_ok;
        logic push_last;
    } sts_t;

endpackage

/* hw/rtl/qtsplit_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module qtsplit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/qtsplit_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle; done when the multiplier runs out.
module qtsplit_mul #(
    parameter int A_WIDTH = 50,
    parameter int B_WIDTH = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [A_WIDTH-1:0] a,
    input  logic [B_WIDTH-1:0] b,
    output logic               done,
    output logic [A_WIDTH-1:0] product
);

    logic [A_WIDTH-1:0] a_reg, a_next;
    logic [B_WIDTH-1:0] b_reg, b_next;
    logic [A_WIDTH-1:0] acc_reg, acc_next;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (load)
        begin
            a_next   = a;
            b_next   = b;
            acc_next = '0;
        end
        else if (b_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next = a_reg << 1;
            b_next = b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign done    = (b_reg == '0);
    assign product = acc_reg;

endmodule

/* hw/rtl/qtsplit_ctrl.sv */
// Sequencer for requests, the mask clearing pass and the quadtree walk.
module qtsplit_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    output logic               out_valid,
    input  logic               out_stall,
    output qtsplit_pkg::cmd_t  cmd,
    input  qtsplit_pkg::sts_t  sts
);
    import qtsplit_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_READ   = 16'h0002,
        ST_CLR    = 16'h0004,
        ST_INIT   = 16'h0008,
        ST_POP    = 16'h0010,
        ST_POPW   = 16'h0020,
        ST_CLIP   = 16'h0040,
        ST_SETUP  = 16'h0080,
        ST_SCAN   = 16'h0100,
        ST_SCANL  = 16'h0200,
        ST_MLOAD  = 16'h0400,
        ST_MWAIT  = 16'h0800,
        ST_DECIDE = 16'h1000,
        ST_MARK   = 16'h2000,
        ST_PUSH   = 16'h4000,
        ST_DONE   = 16'h8000
    } state_t;

    state_t   state_reg, state_next;
    logic     run_reg, run_next;
    mul_sel_t phase_reg, phase_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;
    logic     accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = (state_reg == ST_IDLE) && in_valid && out_free;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        run_next   = run_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func_t'(func))
                        FN_WRITE:
                        begin
                            cmd.img_we   = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ZERO;
                        end
                        FN_RUN:
                        begin
                            cmd.clr_init = 1'b1;
                            run_next     = 1'b1;
                            state_next   = ST_CLR;
                        end
                        FN_READ:
                        begin
                            cmd.rd_latch = 1'b1;
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_ZERO;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_MASK;
                state_next   = ST_IDLE;
            end
            ST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = run_reg ? ST_INIT : ST_IDLE;
                end
            end
            ST_INIT:
            begin
                cmd.stk_init = 1'b1;
                state_next   = ST_POP;
            end
            ST_POP:
            begin
                if (sts.sp_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POPW;
                end
            end
            ST_POPW:
            begin
                cmd.region_load = 1'b1;
                state_next      = ST_CLIP;
            end
            ST_CLIP:
            begin
                cmd.clip_load = 1'b1;
                state_next    = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (sts.empty)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.setup     = 1'b1;
                    cmd.walk_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd   = 1'b1;
                cmd.walk_step = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_SCANL;
                end
            end
            ST_SCANL:
            begin
                // last pixel read is accumulated here
                phase_next = MS_NQ;
                state_next = ST_MLOAD;
            end
            ST_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = phase_reg;
                state_next   = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.mul_store = 1'b1;
                    cmd.mul_sel   = phase_reg;
                    state_next    = ST_MLOAD;
                    unique case (phase_reg)
                        MS_NQ:   phase_next = MS_SS;
                        MS_SS:   phase_next = MS_DN;
                        MS_DN:   phase_next = MS_DNN;
                        MS_DNN:  phase_next = MS_MN;
                        default: state_next = ST_DECIDE;
                    endcase
                end
            end
            ST_DECIDE:
            begin
                priority if (sts.mark_ok)
                begin
                    cmd.walk_init = 1'b1;
                    cmd.count_inc = 1'b1;
                    state_next    = ST_MARK;
                end
                else if (sts.split_ok)
                begin
                    cmd.push_init = 1'b1;
                    state_next    = ST_PUSH;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_MARK:
            begin
                cmd.mask_mark = 1'b1;
                cmd.walk_step = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_POP;
                end
            end
            ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (sts.push_last)
                begin
                    state_next = ST_POP;
                end
            end
            ST_DONE:
            begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_COUNT;
                run_next     = 1'b0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            run_reg       <= 1'b0;
            phase_reg     <= MS_NQ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/qtsplit_dp.sv */
// Datapath: image, mask and region stores, region walker, sums and the split test.
module qtsplit_dp #(
    parameter int MAX_WIDTH   = qtsplit_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = qtsplit_pkg::MAX_HEIGHT_DEF,
    parameter int STACK_DEPTH = qtsplit_pkg::STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  qtsplit_pkg::cmd_t cmd,
    output qtsplit_pkg::sts_t sts,
    input  logic [7:0]        col,
    input  logic [7:0]        row,
    input  logic [7:0]        pixel,
    input  logic [8:0]        image_width,
    input  logic [8:0]        image_height,
    input  logic [8:0]        max_mean,
    input  logic [7:0]        min_std,
    input  logic [8:0]        cell_size,
    output logic [7:0]        mask_value,
    output logic [16:0]       region_count
);
    import qtsplit_pkg::*;

    localparam int PIX  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(PIX);
    localparam int XW   = $clog2(MAX_WIDTH + 1) + 1;
    localparam int YW   = $clog2(MAX_HEIGHT + 1) + 1;
    localparam int NW   = $clog2(PIX + 1);
    localparam int SW   = NW + 8;
    localparam int QW   = NW + 16;
    localparam int PW   = 2 * NW + 16;
    localparam int DW   = XW + YW;
    localparam int EW   = 2 * (XW + YW);
    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int XYW  = (XW > YW) ? XW : YW;
    localparam int CW   = ((XYW > 10) ? XYW : 10) + 1;

    // clipped image size and effective cell
    logic [XW-1:0] iw;
    logic [YW-1:0] ih;
    logic [8:0]    cell_eff;
    logic [9:0]    cell_twice;
    logic [15:0]   sd2;

    assign iw = (32'(image_width) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(image_width);
    assign ih = (32'(image_height) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(image_height);
    assign cell_eff   = (cell_size == 9'd0) ? 9'd1 : cell_size;
    assign cell_twice = {cell_eff, 1'b0};
    assign sd2        = 16'(min_std) * 16'(min_std);

    // request address
    logic [31:0]   in_lin;
    logic [AW-1:0] in_addr;
    logic          in_range;

    assign in_lin   = 32'(row) * 32'(MAX_WIDTH) + 32'(col);
    assign in_addr  = in_lin[AW-1:0];
    assign in_range = (32'(col) < 32'(MAX_WIDTH)) && (32'(row) < 32'(MAX_HEIGHT));

    // control registers
    logic [AW-1:0]  clr_reg, clr_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [16:0]    count_reg, count_next;
    logic           rdv_reg;
    logic [1:0]     pk_reg, pk_next;

    // region and walk registers
    logic [YW-1:0] ry0_reg, rh_reg, ye_reg, wy_reg;
    logic [XW-1:0] rx0_reg, rw_reg, xe_reg, wx_reg;
    logic [NW-1:0] n_reg;
    logic [SW-1:0] s_reg;
    logic [QW-1:0] q_reg;
    logic [PW-1:0] nq_reg, ss_reg, dn_reg, dnn_reg, mn_reg;
    logic          in_range_reg;
    logic [7:0]    mask_value_reg;
    logic [16:0]   region_count_reg;

    // walker
    logic [XW-1:0] wx_inc;
    logic [YW-1:0] wy_inc;
    logic [31:0]   walk_lin;
    logic [AW-1:0] walk_addr;

    assign wx_inc    = wx_reg + XW'(1);
    assign wy_inc    = wy_reg + YW'(1);
    assign walk_lin  = 32'(wy_reg) * 32'(MAX_WIDTH) + 32'(wx_reg);
    assign walk_addr = walk_lin[AW-1:0];

    // clipping
    logic [YW:0]   ye_sum;
    logic [XW:0]   xe_sum;
    logic [YW-1:0] ye_c, dy;
    logic [XW-1:0] xe_c, dx;
    logic [DW-1:0] area;

    assign ye_sum = (YW+1)'(ry0_reg) + (YW+1)'(rh_reg);
    assign xe_sum = (XW+1)'(rx0_reg) + (XW+1)'(rw_reg);
    assign ye_c   = (ye_sum > (YW+1)'(ih)) ? ih : ye_sum[YW-1:0];
    assign xe_c   = (xe_sum > (XW+1)'(iw)) ? iw : xe_sum[XW-1:0];
    assign dy     = ye_reg - ry0_reg;
    assign dx     = xe_reg - rx0_reg;
    assign area   = DW'(dy) * DW'(dx);

    // children
    logic [YW:0]   hh_sum;
    logic [XW:0]   hw_sum;
    logic [YW-1:0] hh, cy;
    logic [XW-1:0] hw, cx;

    assign hh_sum = (YW+1)'(rh_reg) + (YW+1)'(1);
    assign hw_sum = (XW+1)'(rw_reg) + (XW+1)'(1);
    assign hh     = hh_sum[YW:1];
    assign hw     = hw_sum[XW:1];
    // quadrants go on in reverse so the top-left one comes off first
    assign cy     = pk_reg[0] ? ry0_reg : ry0_reg + hh;
    assign cx     = pk_reg[1] ? rx0_reg : rx0_reg + hw;

    // stores
    logic          img_we;
    logic [7:0]    img_rdata;
    logic          mask_we;
    logic [AW-1:0] mask_waddr;
    logic          mask_rdata;
    logic          stk_we;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [EW-1:0] stk_wdata, stk_rdata;
    logic [SPW-1:0] sp_dec;
    logic          stk_room;

    assign img_we     = cmd.img_we & in_range;
    assign mask_we    = cmd.clr_step | cmd.mask_mark;
    assign mask_waddr = cmd.clr_step ? clr_reg : walk_addr;
    assign sp_dec     = sp_reg - SPW'(1);
    assign stk_raddr  = sp_dec[SAW-1:0];
    assign stk_room   = sp_reg < SPW'(STACK_DEPTH);

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = {cy, cx, hh, hw};
        if (cmd.stk_init)
        begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = {YW'(0), XW'(0), ih, iw};
        end
        else if (cmd.push)
        begin
            stk_we = stk_room;
        end
    end

    qtsplit_ram #(.WIDTH(8), .DEPTH(PIX)) u_image (
        .clk   (clk),
        .we    (img_we),
        .waddr (in_addr),
        .wdata (pixel),
        .raddr (walk_addr),
        .rdata (img_rdata)
    );

    qtsplit_ram #(.WIDTH(1), .DEPTH(PIX)) u_mask (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (!cmd.clr_step),
        .raddr (in_addr),
        .rdata (mask_rdata)
    );

    qtsplit_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // multiplier
    logic [PW-1:0] mul_a, mul_p;
    logic [SW-1:0] mul_b;
    logic          mul_done;

    always_comb
    begin
        mul_b = SW'(n_reg);
        unique case (cmd.mul_sel)
            MS_NQ:  mul_a = PW'(q_reg);
            MS_SS:
            begin
                mul_a = PW'(s_reg);
                mul_b = s_reg;
            end
            MS_DN:  mul_a = PW'(sd2);
            MS_DNN: mul_a = dn_reg;
            MS_MN:  mul_a = PW'(max_mean);
            default: mul_a = '0;
        endcase
    end

    qtsplit_mul #(.A_WIDTH(PW), .B_WIDTH(SW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (cmd.mul_load),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    logic [15:0] pix_sq;
    assign pix_sq = 16'(img_rdata) * 16'(img_rdata);

    // control register updates
    always_comb
    begin
        clr_next   = clr_reg;
        sp_next    = sp_reg;
        count_next = count_reg;
        pk_next    = pk_reg;
        if (cmd.clr_init)
        begin
            clr_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_next = clr_reg + AW'(1);
        end
        if (cmd.stk_init)
        begin
            sp_next    = SPW'(1);
            count_next = '0;
        end
        else if (cmd.pop)
        begin
            sp_next = sp_dec;
        end
        else if (cmd.push && stk_room)
        begin
            sp_next = sp_reg + SPW'(1);
        end
        if (cmd.count_inc && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 17'd1;
        end
        if (cmd.push_init)
        begin
            pk_next = 2'd0;
        end
        else if (cmd.push)
        begin
            pk_next = pk_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            sp_reg    <= '0;
            count_reg <= '0;
            rdv_reg   <= 1'b0;
            pk_reg    <= 2'd0;
        end
        else
        begin
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            count_reg <= count_next;
            rdv_reg   <= cmd.scan_rd;
            pk_reg    <= pk_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.region_load)
        begin
            {ry0_reg, rx0_reg, rh_reg, rw_reg} <= stk_rdata;
        end
        if (cmd.clip_load)
        begin
            ye_reg <= ye_c;
            xe_reg <= xe_c;
        end
        if (cmd.setup)
        begin
            n_reg <= area[NW-1:0];
            s_reg <= '0;
            q_reg <= '0;
        end
        else if (rdv_reg)
        begin
            s_reg <= s_reg + SW'(img_rdata);
            q_reg <= q_reg + QW'(pix_sq);
        end
        if (cmd.walk_init)
        begin
            wy_reg <= ry0_reg;
            wx_reg <= rx0_reg;
        end
        else if (cmd.walk_step)
        begin
            if (wx_inc == xe_reg)
            begin
                wx_reg <= rx0_reg;
                wy_reg <= wy_inc;
            end
            else
            begin
                wx_reg <= wx_inc;
            end
        end
        if (cmd.mul_store)
        begin
            unique case (cmd.mul_sel)
                MS_NQ:   nq_reg  <= mul_p;
                MS_SS:   ss_reg  <= mul_p;
                MS_DN:   dn_reg  <= mul_p;
                MS_DNN:  dnn_reg <= mul_p;
                default: mn_reg  <= mul_p;
            endcase
        end
        if (cmd.rd_latch)
        begin
            in_range_reg <= in_range;
        end
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                OUT_MASK:
                begin
                    mask_value_reg   <= (in_range_reg && mask_rdata) ? MASK_ON : 8'd0;
                    region_count_reg <= '0;
                end
                OUT_COUNT:
                begin
                    mask_value_reg   <= 8'd0;
                    region_count_reg <= count_reg;
                end
                default:
                begin
                    mask_value_reg   <= 8'd0;
                    region_count_reg <= '0;
                end
            endcase
        end
    end

    assign mask_value   = mask_value_reg;
    assign region_count = region_count_reg;

    // status
    assign sts.clr_last  = (clr_reg == AW'(PIX - 1));
    assign sts.sp_zero   = (sp_reg == '0);
    assign sts.empty     = (ry0_reg >= ye_reg) || (rx0_reg >= xe_reg);
    assign sts.walk_last = (wy_inc == ye_reg) && (wx_inc == xe_reg);
    assign sts.mul_done  = mul_done;
    // nq >= ss always holds, so the variance difference is never negative
    assign sts.mark_ok   = (PW'(s_reg) < mn_reg)
                         && ((nq_reg - ss_reg) > dnn_reg)
                         && (CW'(rh_reg) < CW'(cell_twice))
                         && (CW'(rw_reg) < CW'(cell_twice));
    assign sts.split_ok  = (CW'(rh_reg) > CW'(cell_eff)) && (CW'(rw_reg) > CW'(cell_eff));
    assign sts.push_last = (pk_reg == 2'd3);

endmodule

/* hw/rtl/quadtree_region_split_mask.sv */
// Quadtree region splitter: top level with configuration registers.
//
// Requests carry func, col, row and pixel; each request gives one result
// (mask_value, region_count). A pixel write and the unused code load their
// result when taken, a mask read goes through the read state and one mask
// RAM read. A run first clears the mask with a pass over all
// MAX_WIDTH*MAX_HEIGHT cells (65536 by default), then walks the region
// stack: per region a setup, a pass over the clipped pixels to sum, five
// serial multiplies, then a pass over the pixels to mark or four quadrant
// pushes. After reset the same mask clearing pass runs; requests are
// stalled until it ends, configuration writes are taken at any time.
module quadtree_region_split_mask #(
    parameter int MAX_WIDTH   = qtsplit_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = qtsplit_pkg::MAX_HEIGHT_DEF,
    parameter int STACK_DEPTH = qtsplit_pkg::STACK_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      func,
    input  logic [7:0]                      col,
    input  logic [7:0]                      row,
    input  logic [7:0]                      pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      mask_value,
    output logic [16:0]                     region_count,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qtsplit_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import qtsplit_pkg::*;

    logic [8:0] width_reg, height_reg, mean_reg, cell_reg;
    logic [7:0] std_reg;
    logic       cfg_wr;
    reg_idx_t   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            mean_reg   <= MEAN_RST;
            std_reg    <= STD_RST;
            cell_reg   <= CELL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[8:0];
                REG_MEAN:   mean_reg   <= pwdata[8:0];
                REG_STD:    std_reg    <= pwdata[7:0];
                REG_CELL:   cell_reg   <= pwdata[8:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_MEAN:   prdata = 32'(mean_reg);
            REG_STD:    prdata = 32'(std_reg);
            REG_CELL:   prdata = 32'(cell_reg);
            default:    prdata = 32'd0;
        endcase
    end

    cmd_t cmd;
    sts_t sts;

    qtsplit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    qtsplit_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .col          (col),
        .row          (row),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .max_mean     (mean_reg),
        .min_std      (std_reg),
        .cell_size    (cell_reg),
        .mask_value   (mask_value),
        .region_count (region_count)
    );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for quadtree_region_split_mask: random requests, predicted results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qtsplit_pkg::*;

    localparam int IMG_W = 256;
    localparam int IMG_H = 256;
    localparam int STK_N = 32;

    typedef struct {
        func_t      fn;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] pixel;
    } request_t;

    typedef struct {
        logic [7:0]  mask_value;
        logic [16:0] region_count;
    } result_t;

    typedef struct {
        int y0;
        int x0;
        int h;
        int w;
    } region_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [7:0] col = '0;
    logic [7:0] row = '0;
    logic [7:0] pixel = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] mask_value;
    logic [16:0] region_count;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    quadtree_region_split_mask u_dut (.*);

    request_t pending_q[$];
    result_t  result_q[$];
    int       errs = 0;
    bit       quiet = 1'b0;
    bit       in_taken = 1'b0;
    int       in_gap = 0;
    int       stall_cnt = 0;

    // predictor state
    logic [7:0] img_mem[IMG_W*IMG_H];
    bit         mask_mem[IMG_W*IMG_H];
    bit         written[IMG_W*IMG_H];
    region_t    rstack[STK_N];
    int         rsp;
    logic [8:0] cfg_w = WIDTH_RST, cfg_h = HEIGHT_RST, cfg_mean = MEAN_RST, cfg_cell = CELL_RST;
    logic [7:0] cfg_std = STD_RST;

    initial forever #10 clk = ~clk;

    initial
    begin
        #200000000;
        $display("quadtree_region_split_mask: mismatch");
        $finish;
    end

    task automatic report(string what, longint got, longint want);
        $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errs++;
    endtask

    function automatic void push_region(int y0, int x0, int h, int w);
        if (rsp < STK_N)
        begin
            rstack[rsp] = '{y0, x0, h, w};
            rsp++;
        end
    endfunction

    function automatic logic [16:0] split_image();
        int iw, ih, cl, ye, xe, hh, hw;
        longint unsigned n, s, q, pv, sd2;
        logic [16:0] marks;
        region_t r;
        iw = (cfg_w > IMG_W) ? IMG_W : cfg_w;
        ih = (cfg_h > IMG_H) ? IMG_H : cfg_h;
        cl = (cfg_cell == 0) ? 1 : cfg_cell;
        sd2 = longint'(cfg_std) * cfg_std;
        marks = '0;
        foreach (mask_mem[i]) mask_mem[i] = 1'b0;
        rsp = 0;
        push_region(0, 0, ih, iw);
        while (rsp > 0)
        begin
            rsp--;
            r = rstack[rsp];
            ye = (r.y0 + r.h > ih) ? ih : r.y0 + r.h;
            xe = (r.x0 + r.w > iw) ? iw : r.x0 + r.w;
            if (r.y0 >= ye || r.x0 >= xe)
                continue;
            n = longint'(ye - r.y0) * (xe - r.x0);
            s = 0;
            q = 0;
            for (int y = r.y0; y < ye; y++)
                for (int x = r.x0; x < xe; x++)
                begin
                    pv = img_mem[y*IMG_W + x];
                    s += pv;
                    q += pv * pv;
                end
            if (s < longint'(cfg_mean) * n && n*q - s*s > sd2*n*n
                && r.h < 2*cl && r.w < 2*cl)
            begin
                for (int y = r.y0; y < ye; y++)
                    for (int x = r.x0; x < xe; x++)
                        mask_mem[y*IMG_W + x] = 1'b1;
                if (marks != COUNT_MAX)
                    marks++;
            end
            else if (r.h > cl && r.w > cl)
            begin
                hh = (r.h + 1) / 2;
                hw = (r.w + 1) / 2;
                // reverse order so the first quadrant pops first
                push_region(r.y0 + hh, r.x0 + hw, hh, hw);
                push_region(r.y0, r.x0 + hw, hh, hw);
                push_region(r.y0 + hh, r.x0, hh, hw);
                push_region(r.y0, r.x0, hh, hw);
            end
        end
        return marks;
    endfunction

    function automatic result_t apply_request(request_t rq);
        result_t res;
        int idx;
        res = '{8'd0, 17'd0};
        idx = int'(rq.row) * IMG_W + int'(rq.col);
        case (rq.fn)
            FN_WRITE: img_mem[idx] = rq.pixel;
            FN_RUN:   res.region_count = split_image();
            FN_READ:  if (mask_mem[idx]) res.mask_value = MASK_ON;
            default: ;
        endcase
        return res;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0)
            begin
                in_gap = $urandom_range(0, 10);
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                request_t rq;
                rq = pending_q.pop_front();
                func <= rq.fn;
                col <= rq.col;
                row <= rq.row;
                pixel <= rq.pixel;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result-side backpressure
    always @(negedge clk)
    begin
        if (stall_cnt > 0)
        begin
            stall_cnt--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_cnt = $urandom_range(0, 10);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: predict on accepted request, check accepted result
    always @(posedge clk)
    begin
        result_t got, want;
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            result_q.push_back(apply_request('{func_t'(func), col, row, pixel}));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{mask_value, region_count};
            if (result_q.size() == 0)
                report("unexpected result, mask_value", got.mask_value, -1);
            else
            begin
                want = result_q.pop_front();
                if (got.mask_value !== want.mask_value)
                    report("mask_value", got.mask_value, want.mask_value);
                if (got.region_count !== want.region_count)
                    report("region_count", got.region_count, want.region_count);
            end
        end
    end

    task automatic wait_idle();
        wait (pending_q.size() == 0 && !in_valid && result_q.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(reg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_w = v[8:0];
            REG_HEIGHT: cfg_h = v[8:0];
            REG_MEAN:   cfg_mean = v[8:0];
            REG_STD:    cfg_std = v[7:0];
            REG_CELL:   cfg_cell = v[8:0];
            default: ;
        endcase
    endtask

    task automatic add_req(func_t fn, int c, int r, int p);
        pending_q.push_back('{fn, 8'(c), 8'(r), 8'(p)});
        if (fn == FN_WRITE)
            written[r*IMG_W + c] = 1'b1;
    endtask

    function automatic int textured(int r, int c);
        if (((r >> 2) ^ (c >> 2)) & 1)
            return $urandom_range(0, 255);
        return $urandom_range(0, 45);
    endfunction

    task automatic add_random(int cnt);
        int k;
        repeat (cnt)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)
                add_req(FN_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
            else if (k < 70)
                add_req(FN_READ, $urandom_range(0, 255), $urandom_range(0, 255), 0);
            else if (k < 94)
                add_req(FN_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 255));
            else
                add_req(FN_NOP, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end
    endtask

    // one setting: program registers, cover the image, run once, read back
    task automatic phase(int w, int h, int mn, int sd, int cl);
        int iw, ih;
        wait_idle();
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_MEAN, mn);
        cfg_write(REG_STD, sd);
        cfg_write(REG_CELL, cl);
        iw = (w > IMG_W) ? IMG_W : w;
        ih = (h > IMG_H) ? IMG_H : h;
        // the walk reads every pixel of the image, so all must be written first
        for (int y = 0; y < ih; y++)
            for (int x = 0; x < iw; x++)
                if (!written[y*IMG_W + x])
                    add_req(FN_WRITE, x, y, textured(y, x));
        add_random(25);
        add_req(FN_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
        add_random(80);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every code, writes beyond the image
        add_req(FN_WRITE, 255, 255, 255);
        add_req(FN_WRITE, 0, 255, 0);
        add_req(FN_READ, 255, 255, 0);
        add_req(FN_NOP, 255, 255, 255);
        wait_idle();
        cfg_write(REG_WIDTH, 8);
        cfg_write(REG_HEIGHT, 8);
        add_req(FN_WRITE, 0, 0, 0);
        add_req(FN_WRITE, 7, 7, 255);
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                if (!written[y*IMG_W + x])
                    add_req(FN_WRITE, x, y, textured(y, x));
        add_req(FN_RUN, 0, 0, 0);
        add_req(FN_READ, 0, 0, 0);
        add_req(FN_READ, 255, 0, 0);
        add_req(FN_READ, 0, 255, 0);

        phase(8, 8, 95, 10, 4);
        phase(1, 1, 256, 0, 1);
        phase(256, 1, 256, 0, 256);
        phase(1, 511, 200, 5, 256);         // height above range saturates
        phase(0, 16, 95, 10, 0);            // empty image, cell of zero
        phase(13, 11, 0, 255, 3);
        phase(16, 12, 128, 20, 2);
        phase(16, 16, 120, 8, 1);           // deepest split
        phase(9, 7, 95, 10, 32);
        wait_idle();
        quiet = 1'b1;
        phase(12, 12, 100, 10, 2);
        wait_idle();
        repeat (50) @(posedge clk);
        if (errs == 0)
            $display("quadtree_region_split_mask: match");
        else
            $display("quadtree_region_split_mask: mismatch");
        $finish;
    end
endmodule

/* quadtree_region_split_mask.f */
hw/rtl/qtsplit_pkg.sv
hw/rtl/qtsplit_ram.sv
hw/rtl/qtsplit_mul.sv
hw/rtl/qtsplit_ctrl.sv
hw/rtl/qtsplit_dp.sv
hw/rtl/quadtree_region_split_mask.sv
tb/sv/tb.sv
